/* hdl/ksf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_pkg
// Types and constants shared by the spanning forest block.
// ----------------------------------------------------------------------------
package ksf_pkg;

	localparam int CITY_W = 8;
	localparam int LEN_W = 16;
	localparam int CC_W = 9;
	// stored edge word: {length, first city, second city}
	localparam int EDGE_W = LEN_W + 2 * CITY_W;
	localparam logic [CC_W-1:0] CC_RESET = 9'd256;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FI_RD, S_FI_WR,
		S_SO_KEY, S_SO_KEYW, S_SO_RD, S_SO_CMP, S_SO_PUT,
		S_INIT,
		S_SC_RD, S_SC_EDGE, S_SC_FRD, S_SC_FCMP,
		S_CP_START, S_CP_FRD, S_CP_FCMP, S_CP_UPD,
		S_GS_RD, S_GS_KEY, S_GS_ORD, S_GS_CMP, S_GS_PUT,
		S_AR_G, S_AR_GW, S_AR_J, S_AR_EW, S_AR_CMP,
		S_FE_RD, S_FE_DO, S_EMIT
	} ksf_state_t;

	typedef struct packed {
		logic              cmd;
		logic [CITY_W-1:0] city_a;
		logic [CITY_W-1:0] city_b;
		logic [LEN_W-1:0]  edge_length;
		logic              last_edge;
	} ksf_in_t;

	typedef struct packed {
		logic              valid_res;
		logic [CITY_W-1:0] city_a;
		logic [CITY_W-1:0] city_b;
		logic [LEN_W-1:0]  length;
		logic              empty_group;
		logic              end_of_group;
		logic              end_of_forest;
	} ksf_res_t;

endpackage

/* hdl/ksf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ksf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/ksf_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_cmp
// Shared key comparator: unsigned less-than and equality.
// ----------------------------------------------------------------------------
module ksf_cmp (
	input  logic [31:0] x,
	input  logic [31:0] y,
	output logic        lt,
	output logic        eq
);

	assign lt = (x < y);
	assign eq = (x == y);

endmodule

/* hdl/ksf_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_core
// Sequencer for edge load, sort, union-find, grouping and fetch.
// ----------------------------------------------------------------------------
module ksf_core #(
	parameter int MAX_CITIES = 256,
	parameter int MAX_EDGES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ksf_pkg::CC_W-1:0]    city_count,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ksf_pkg::ksf_in_t            in_item,
	output logic                        res_valid,
	output ksf_pkg::ksf_res_t           res,
	input  logic                        res_take
);

	localparam int CW = $clog2(MAX_CITIES);
	localparam int NW = CW + 1;
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int TW = $clog2(MAX_EDGES + 1);
	localparam int IW = (TW > NW) ? TW : NW;
	localparam int OW = NW + 2 * CW;
	localparam int EDW = ksf_pkg::EDGE_W;
	localparam int SW = NW + CW;

	ksf_pkg::ksf_state_t state_q, state_d;

	logic           out_phase_q, out_phase_d;
	logic           sel_b_q, sel_b_d;
	logic [TW-1:0]  edge_total_q, edge_total_d;
	logic [NW-1:0]  acc_total_q, acc_total_d;
	logic [NW-1:0]  grp_total_q, grp_total_d;
	logic [NW-1:0]  grp_q, grp_d, pos_q, pos_d, ingrp_q, ingrp_d;
	logic [IW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
	logic [NW-1:0]  n_q, n_d;
	logic [EDW-1:0] key_q, key_d;
	logic [OW-1:0]  gkey_q, gkey_d;
	logic [CW-1:0]  c_q, c_d, f1_q, f1_d, r_q, r_d;
	ksf_pkg::ksf_res_t res_q, res_d;

	// memory ports
	logic           ed_we;
	logic [EW-1:0]  ed_waddr, ed_raddr;
	logic [EDW-1:0] ed_wdata, ed_rdata;
	logic           par_we;
	logic [CW-1:0]  par_waddr, par_raddr, par_wdata, par_rdata;
	logic           cs_we;
	logic [CW-1:0]  cs_waddr, cs_raddr;
	logic [SW-1:0]  cs_wdata, cs_rdata;
	logic           rt_we;
	logic [CW-1:0]  rt_waddr, rt_raddr, rt_wdata, rt_rdata;
	logic           ac_we;
	logic [CW-1:0]  ac_waddr, ac_raddr;
	logic [EDW-1:0] ac_wdata, ac_rdata;
	logic           go_we;
	logic [CW-1:0]  go_waddr, go_raddr;
	logic [OW-1:0]  go_wdata, go_rdata;
	logic           fo_we;
	logic [CW-1:0]  fo_waddr, fo_raddr;
	logic [EDW-1:0] fo_wdata, fo_rdata;

	logic [31:0]    cx, cy;
	logic           c_lt, c_eq;

	logic [NW-1:0]  n_c;
	logic [TW-1:0]  et_base;
	logic [IW-1:0]  jm1;
	logic [ksf_pkg::CITY_W-1:0] lo, hi;
	logic [NW-1:0]  size_c, need_c;
	logic           last_c;

	ksf_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
		.raddr(ed_raddr), .rdata(ed_rdata));
	ksf_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_parent (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.raddr(par_raddr), .rdata(par_rdata));
	ksf_ram #(.WIDTH(SW), .DEPTH(MAX_CITIES)) u_csize (
		.clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
		.raddr(cs_raddr), .rdata(cs_rdata));
	ksf_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_root (
		.clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
		.raddr(rt_raddr), .rdata(rt_rdata));
	ksf_ram #(.WIDTH(EDW), .DEPTH(MAX_CITIES)) u_accept (
		.clk(clk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
		.raddr(ac_raddr), .rdata(ac_rdata));
	ksf_ram #(.WIDTH(OW), .DEPTH(MAX_CITIES)) u_gorder (
		.clk(clk), .we(go_we), .waddr(go_waddr), .wdata(go_wdata),
		.raddr(go_raddr), .rdata(go_rdata));
	ksf_ram #(.WIDTH(EDW), .DEPTH(MAX_CITIES)) u_forest (
		.clk(clk), .we(fo_we), .waddr(fo_waddr), .wdata(fo_wdata),
		.raddr(fo_raddr), .rdata(fo_rdata));

	ksf_cmp u_cmp (.x(cx), .y(cy), .lt(c_lt), .eq(c_eq));

	assign in_ready = (state_q == ksf_pkg::S_IDLE);
	assign res_valid = (state_q == ksf_pkg::S_EMIT);
	assign res = res_q;

	always_comb begin
		if (city_count == '0) begin
			n_c = NW'(1);
		end else if (32'(city_count) > MAX_CITIES) begin
			n_c = NW'(MAX_CITIES);
		end else begin
			n_c = NW'(city_count);
		end
	end

	assign et_base = out_phase_q ? '0 : edge_total_q;
	assign jm1 = j_q - 1'b1;
	assign lo = (in_item.city_a < in_item.city_b) ? in_item.city_a : in_item.city_b;
	assign hi = (in_item.city_a < in_item.city_b) ? in_item.city_b : in_item.city_a;
	assign size_c = go_rdata[OW-1:2*CW];
	assign need_c = size_c - 1'b1;
	assign last_c = ((grp_q + 1'b1) == grp_total_q);

	always_comb begin
		state_d = state_q;
		out_phase_d = out_phase_q;
		sel_b_d = sel_b_q;
		edge_total_d = edge_total_q;
		acc_total_d = acc_total_q;
		grp_total_d = grp_total_q;
		grp_d = grp_q;
		pos_d = pos_q;
		ingrp_d = ingrp_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		n_d = n_q;
		key_d = key_q;
		gkey_d = gkey_q;
		c_d = c_q;
		f1_d = f1_q;
		r_d = r_q;
		res_d = res_q;
		ed_we = 1'b0; ed_waddr = '0; ed_wdata = '0; ed_raddr = '0;
		par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_raddr = '0;
		cs_we = 1'b0; cs_waddr = '0; cs_wdata = '0; cs_raddr = '0;
		rt_we = 1'b0; rt_waddr = '0; rt_wdata = '0; rt_raddr = '0;
		ac_we = 1'b0; ac_waddr = '0; ac_wdata = '0; ac_raddr = '0;
		go_we = 1'b0; go_waddr = '0; go_wdata = '0; go_raddr = '0;
		fo_we = 1'b0; fo_waddr = '0; fo_wdata = '0; fo_raddr = '0;
		cx = '0;
		cy = '0;

		case (state_q)
			ksf_pkg::S_IDLE: begin
				if (in_valid && in_item.cmd == ksf_pkg::CMD_LOAD) begin
					// a load after a finished forest starts a new set
					out_phase_d = 1'b0;
					if (out_phase_q) begin
						grp_total_d = '0;
					end
					edge_total_d = et_base;
					if (32'(et_base) < MAX_EDGES) begin
						ed_we = 1'b1;
						ed_waddr = EW'(et_base);
						ed_wdata = {in_item.edge_length, lo, hi};
						edge_total_d = et_base + 1'b1;
					end
					if (in_item.last_edge) begin
						n_d = n_c;
						i_d = '0;
						k_d = '0;
						state_d = ksf_pkg::S_FI_RD;
					end
				end else if (in_valid) begin
					if (!out_phase_q || grp_q >= grp_total_q) begin
						res_d = '0;
						state_d = ksf_pkg::S_EMIT;
					end else begin
						state_d = ksf_pkg::S_FE_RD;
					end
				end
			end

			// drop edges with an endpoint out of range
			ksf_pkg::S_FI_RD: begin
				if (i_q == IW'(edge_total_q)) begin
					edge_total_d = TW'(k_q);
					i_d = IW'(1);
					state_d = ksf_pkg::S_SO_KEY;
				end else begin
					ed_raddr = i_q[EW-1:0];
					state_d = ksf_pkg::S_FI_WR;
				end
			end
			ksf_pkg::S_FI_WR: begin
				if (32'(ed_rdata[ksf_pkg::CITY_W-1:0]) < 32'(n_q)) begin
					ed_we = 1'b1;
					ed_waddr = k_q[EW-1:0];
					ed_wdata = ed_rdata;
					k_d = k_q + 1'b1;
				end
				i_d = i_q + 1'b1;
				state_d = ksf_pkg::S_FI_RD;
			end

			// insertion sort, one shift per compare
			ksf_pkg::S_SO_KEY: begin
				if (i_q >= IW'(edge_total_q)) begin
					i_d = '0;
					state_d = ksf_pkg::S_INIT;
				end else begin
					ed_raddr = i_q[EW-1:0];
					state_d = ksf_pkg::S_SO_KEYW;
				end
			end
			ksf_pkg::S_SO_KEYW: begin
				key_d = ed_rdata;
				j_d = i_q;
				state_d = ksf_pkg::S_SO_RD;
			end
			ksf_pkg::S_SO_RD: begin
				if (j_q == '0) begin
					state_d = ksf_pkg::S_SO_PUT;
				end else begin
					ed_raddr = jm1[EW-1:0];
					state_d = ksf_pkg::S_SO_CMP;
				end
			end
			ksf_pkg::S_SO_CMP: begin
				cx = key_q;
				cy = ed_rdata;
				if (c_lt) begin
					ed_we = 1'b1;
					ed_waddr = j_q[EW-1:0];
					ed_wdata = ed_rdata;
					j_d = jm1;
					state_d = ksf_pkg::S_SO_RD;
				end else begin
					state_d = ksf_pkg::S_SO_PUT;
				end
			end
			ksf_pkg::S_SO_PUT: begin
				ed_we = 1'b1;
				ed_waddr = j_q[EW-1:0];
				ed_wdata = key_q;
				i_d = i_q + 1'b1;
				state_d = ksf_pkg::S_SO_KEY;
			end

			ksf_pkg::S_INIT: begin
				par_we = 1'b1;
				par_waddr = i_q[CW-1:0];
				par_wdata = i_q[CW-1:0];
				cs_we = 1'b1;
				cs_waddr = i_q[CW-1:0];
				cs_wdata = '0;
				if (i_q == IW'(n_q) - 1'b1) begin
					i_d = '0;
					acc_total_d = '0;
					state_d = ksf_pkg::S_SC_RD;
				end else begin
					i_d = i_q + 1'b1;
				end
			end

			// Kruskal scan: find both roots, link second under first
			ksf_pkg::S_SC_RD: begin
				if (i_q == IW'(edge_total_q)) begin
					i_d = '0;
					state_d = ksf_pkg::S_CP_START;
				end else begin
					ed_raddr = i_q[EW-1:0];
					state_d = ksf_pkg::S_SC_EDGE;
				end
			end
			ksf_pkg::S_SC_EDGE: begin
				key_d = ed_rdata;
				c_d = CW'(ed_rdata[2*ksf_pkg::CITY_W-1:ksf_pkg::CITY_W]);
				sel_b_d = 1'b0;
				state_d = ksf_pkg::S_SC_FRD;
			end
			ksf_pkg::S_SC_FRD: begin
				par_raddr = c_q;
				state_d = ksf_pkg::S_SC_FCMP;
			end
			ksf_pkg::S_SC_FCMP: begin
				cx = 32'(f1_q);
				cy = 32'(c_q);
				if (par_rdata == c_q) begin
					if (!sel_b_q) begin
						f1_d = c_q;
						c_d = CW'(key_q[ksf_pkg::CITY_W-1:0]);
						sel_b_d = 1'b1;
						state_d = ksf_pkg::S_SC_FRD;
					end else begin
						if (!c_eq) begin
							par_we = 1'b1;
							par_waddr = c_q;
							par_wdata = f1_q;
							ac_we = 1'b1;
							ac_waddr = acc_total_q[CW-1:0];
							ac_wdata = key_q;
							acc_total_d = acc_total_q + 1'b1;
						end
						i_d = i_q + 1'b1;
						state_d = ksf_pkg::S_SC_RD;
					end
				end else begin
					c_d = par_rdata;
					state_d = ksf_pkg::S_SC_FRD;
				end
			end

			// size and smallest member per root, root of each city
			ksf_pkg::S_CP_START: begin
				c_d = i_q[CW-1:0];
				state_d = ksf_pkg::S_CP_FRD;
			end
			ksf_pkg::S_CP_FRD: begin
				par_raddr = c_q;
				state_d = ksf_pkg::S_CP_FCMP;
			end
			ksf_pkg::S_CP_FCMP: begin
				if (par_rdata == c_q) begin
					f1_d = c_q;
					cs_raddr = c_q;
					rt_we = 1'b1;
					rt_waddr = i_q[CW-1:0];
					rt_wdata = c_q;
					state_d = ksf_pkg::S_CP_UPD;
				end else begin
					c_d = par_rdata;
					state_d = ksf_pkg::S_CP_FRD;
				end
			end
			ksf_pkg::S_CP_UPD: begin
				cs_we = 1'b1;
				cs_waddr = f1_q;
				cs_wdata = {cs_rdata[SW-1:CW] + 1'b1,
					(cs_rdata[SW-1:CW] == '0) ? i_q[CW-1:0] : cs_rdata[CW-1:0]};
				if (i_q == IW'(n_q) - 1'b1) begin
					i_d = '0;
					grp_total_d = '0;
					state_d = ksf_pkg::S_GS_RD;
				end else begin
					i_d = i_q + 1'b1;
					state_d = ksf_pkg::S_CP_START;
				end
			end

			// insert each root into the group list, descending key
			ksf_pkg::S_GS_RD: begin
				if (i_q == IW'(n_q)) begin
					i_d = '0;
					k_d = '0;
					state_d = ksf_pkg::S_AR_G;
				end else begin
					cs_raddr = i_q[CW-1:0];
					state_d = ksf_pkg::S_GS_KEY;
				end
			end
			ksf_pkg::S_GS_KEY: begin
				if (cs_rdata[SW-1:CW] == '0) begin
					i_d = i_q + 1'b1;
					state_d = ksf_pkg::S_GS_RD;
				end else begin
					gkey_d = {cs_rdata, i_q[CW-1:0]};
					j_d = IW'(grp_total_q);
					grp_total_d = grp_total_q + 1'b1;
					state_d = ksf_pkg::S_GS_ORD;
				end
			end
			ksf_pkg::S_GS_ORD: begin
				if (j_q == '0) begin
					state_d = ksf_pkg::S_GS_PUT;
				end else begin
					go_raddr = jm1[CW-1:0];
					state_d = ksf_pkg::S_GS_CMP;
				end
			end
			ksf_pkg::S_GS_CMP: begin
				cx = 32'(go_rdata[OW-1:CW]);
				cy = 32'(gkey_q[OW-1:CW]);
				if (c_lt) begin
					go_we = 1'b1;
					go_waddr = j_q[CW-1:0];
					go_wdata = go_rdata;
					j_d = jm1;
					state_d = ksf_pkg::S_GS_ORD;
				end else begin
					state_d = ksf_pkg::S_GS_PUT;
				end
			end
			ksf_pkg::S_GS_PUT: begin
				go_we = 1'b1;
				go_waddr = j_q[CW-1:0];
				go_wdata = gkey_q;
				i_d = i_q + 1'b1;
				state_d = ksf_pkg::S_GS_RD;
			end

			// lay out forest edges group by group, newest first
			ksf_pkg::S_AR_G: begin
				if (i_q == IW'(grp_total_q)) begin
					out_phase_d = 1'b1;
					grp_d = '0;
					pos_d = '0;
					ingrp_d = '0;
					state_d = ksf_pkg::S_IDLE;
				end else begin
					go_raddr = i_q[CW-1:0];
					state_d = ksf_pkg::S_AR_GW;
				end
			end
			ksf_pkg::S_AR_GW: begin
				r_d = go_rdata[CW-1:0];
				j_d = IW'(acc_total_q);
				state_d = ksf_pkg::S_AR_J;
			end
			ksf_pkg::S_AR_J: begin
				if (j_q == '0) begin
					i_d = i_q + 1'b1;
					state_d = ksf_pkg::S_AR_G;
				end else begin
					ac_raddr = jm1[CW-1:0];
					state_d = ksf_pkg::S_AR_EW;
				end
			end
			ksf_pkg::S_AR_EW: begin
				key_d = ac_rdata;
				rt_raddr = CW'(ac_rdata[2*ksf_pkg::CITY_W-1:ksf_pkg::CITY_W]);
				state_d = ksf_pkg::S_AR_CMP;
			end
			ksf_pkg::S_AR_CMP: begin
				cx = 32'(rt_rdata);
				cy = 32'(r_q);
				if (c_eq) begin
					fo_we = 1'b1;
					fo_waddr = k_q[CW-1:0];
					fo_wdata = key_q;
					k_d = k_q + 1'b1;
				end
				j_d = jm1;
				state_d = ksf_pkg::S_AR_J;
			end

			ksf_pkg::S_FE_RD: begin
				go_raddr = grp_q[CW-1:0];
				fo_raddr = pos_q[CW-1:0];
				state_d = ksf_pkg::S_FE_DO;
			end
			ksf_pkg::S_FE_DO: begin
				res_d = '0;
				res_d.valid_res = 1'b1;
				if (need_c == '0 || pos_q >= acc_total_q) begin
					res_d.empty_group = 1'b1;
					res_d.end_of_group = 1'b1;
					res_d.end_of_forest = last_c;
					grp_d = grp_q + 1'b1;
					ingrp_d = '0;
				end else begin
					res_d.length = fo_rdata[EDW-1:2*ksf_pkg::CITY_W];
					res_d.city_a = fo_rdata[2*ksf_pkg::CITY_W-1:ksf_pkg::CITY_W];
					res_d.city_b = fo_rdata[ksf_pkg::CITY_W-1:0];
					pos_d = pos_q + 1'b1;
					ingrp_d = ingrp_q + 1'b1;
					if (ingrp_q + 1'b1 >= need_c) begin
						res_d.end_of_group = 1'b1;
						res_d.end_of_forest = last_c;
						grp_d = grp_q + 1'b1;
						ingrp_d = '0;
					end
				end
				state_d = ksf_pkg::S_EMIT;
			end
			ksf_pkg::S_EMIT: begin
				if (res_take) begin
					state_d = ksf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ksf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksf_pkg::S_IDLE;
			out_phase_q <= 1'b0;
			sel_b_q <= 1'b0;
			edge_total_q <= '0;
			acc_total_q <= '0;
			grp_total_q <= '0;
			grp_q <= '0;
			pos_q <= '0;
			ingrp_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			out_phase_q <= out_phase_d;
			sel_b_q <= sel_b_d;
			edge_total_q <= edge_total_d;
			acc_total_q <= acc_total_d;
			grp_total_q <= grp_total_d;
			grp_q <= grp_d;
			pos_q <= pos_d;
			ingrp_q <= ingrp_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		key_q <= key_d;
		gkey_q <= gkey_d;
		c_q <= c_d;
		f1_q <= f1_d;
		r_q <= r_d;
		res_q <= res_d;
	end

endmodule

/* hdl/kruskal_spanning_forest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_spanning_forest
// Minimum spanning forest by Kruskal and union-find, grouped read-out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries load items (cmd 0: one edge)
//    and fetch items (cmd 1). The item with last_edge set ends the edge set.
//  - Output channel (out_valid/out_ready) carries one result item per fetch;
//    loads give none. A fetch before a forest exists or past its end returns
//    an item with valid_res low and all fields zero.
//  - city_count is written through cfg_we/cfg_data. The user must write it
//    only while the block is idle; the block itself does not enforce this.
//  - Loads can run back to back. A fetch with nothing to return builds an
//    idle item; any other reads the group and forest tables in parallel, then
//    builds the item. The next item is taken once the output register holds it.
//  - After the last edge the sequencer runs alone, in_ready low: it filters
//    the edges, sorts them by insertion, resets the union-find tables, scans
//    the edges finding both roots of each, runs the component pass, inserts
//    the groups in order and lays the forest out.
//  - Reset clears control only; the edge and forest tables need no clearing.
//  - A result waits in the output register while out_ready is low; loads
//    are still taken meanwhile. A second fetch is taken, but its result
//    waits in the core and holds in_ready low until the register frees.
// ----------------------------------------------------------------------------
module kruskal_spanning_forest #(
	parameter int MAX_CITIES = 256,
	parameter int MAX_EDGES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ksf_pkg::CC_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [ksf_pkg::CITY_W-1:0]    city_a,
	input  logic [ksf_pkg::CITY_W-1:0]    city_b,
	input  logic [ksf_pkg::LEN_W-1:0]     edge_length,
	input  logic                          last_edge,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          valid_res,
	output logic [ksf_pkg::CITY_W-1:0]    out_city_a,
	output logic [ksf_pkg::CITY_W-1:0]    out_city_b,
	output logic [ksf_pkg::LEN_W-1:0]     out_length,
	output logic                          empty_group,
	output logic                          end_of_group,
	output logic                          end_of_forest
);

	logic [ksf_pkg::CC_W-1:0] city_count_q;
	ksf_pkg::ksf_in_t  in_item;
	ksf_pkg::ksf_res_t core_res, res_q;
	logic core_res_valid, res_take, out_valid_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= ksf_pkg::CC_RESET;
		end else if (cfg_we) begin
			city_count_q <= cfg_data;
		end
	end

	assign in_item = '{cmd: cmd, city_a: city_a, city_b: city_b,
		edge_length: edge_length, last_edge: last_edge};

	ksf_core #(.MAX_CITIES(MAX_CITIES), .MAX_EDGES(MAX_EDGES)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.city_count(city_count_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.res_valid(core_res_valid),
		.res(core_res),
		.res_take(res_take)
	);

	// output register: fills when empty or draining in the same cycle
	assign res_take = core_res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= core_res;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = res_q.valid_res;
	assign out_city_a = res_q.city_a;
	assign out_city_b = res_q.city_b;
	assign out_length = res_q.length;
	assign empty_group = res_q.empty_group;
	assign end_of_group = res_q.end_of_group;
	assign end_of_forest = res_q.end_of_forest;

endmodule

/* bench/kruskal_spanning_forest_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_spanning_forest_tb
// Self-checking bench for the minimum spanning forest block.
// ----------------------------------------------------------------------------
// A short table of directed items comes first. Rows whose answer is plain
// (a fetch with no forest behind it, or past its end) carry that answer
// typed in; every other row is checked against a local union-find forest
// model. Then a full edge store, then random edge sets under a range of city
// counts. The sender runs in bursts with gaps, and the receiver stalls on its
// own pattern. One long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module kruskal_spanning_forest_tb;

	localparam int NCITY = 256;
	localparam int NEDGE = 1024;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 200;
	localparam int FULL_FETCHES = 12;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ksf_pkg::CC_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic cmd;
	logic [ksf_pkg::CITY_W-1:0] city_a, city_b;
	logic [ksf_pkg::LEN_W-1:0] edge_length;
	logic last_edge;
	logic out_valid, out_ready;
	logic valid_res;
	logic [ksf_pkg::CITY_W-1:0] out_city_a, out_city_b;
	logic [ksf_pkg::LEN_W-1:0] out_length;
	logic empty_group, end_of_group, end_of_forest;

	kruskal_spanning_forest i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .city_a(city_a), .city_b(city_b),
		.edge_length(edge_length), .last_edge(last_edge),
		.out_valid(out_valid), .out_ready(out_ready),
		.valid_res(valid_res), .out_city_a(out_city_a), .out_city_b(out_city_b),
		.out_length(out_length), .empty_group(empty_group),
		.end_of_group(end_of_group), .end_of_forest(end_of_forest)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Forest model: own copy of the edge store, union-find and cursors
	// ------------------------------------------------------------------
	int unsigned cities_cfg;
	logic [ksf_pkg::CITY_W-1:0] st_a [NEDGE];
	logic [ksf_pkg::CITY_W-1:0] st_b [NEDGE];
	logic [ksf_pkg::LEN_W-1:0] st_len [NEDGE];
	int unsigned edge_cnt;
	int unsigned parent [NCITY];
	int unsigned comp_size [NCITY];
	int unsigned comp_min [NCITY];
	int unsigned kept [NCITY];
	int unsigned kept_cnt;
	int unsigned grp_order [NCITY];
	int unsigned grp_cnt;
	bit showing;            // forest built and being read out
	int unsigned cur_grp, cur_pos, cur_in_grp;
	int unsigned forest_len; // items the current forest yields

	ksf_pkg::ksf_res_t pending_forest_items [$];

	int unsigned err_cnt;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned sets_run;
	int unsigned cycles;

	function automatic int unsigned live_cities();
		if (cities_cfg == 0) return 1;
		if (cities_cfg > NCITY) return NCITY;
		return cities_cfg;
	endfunction

	// bounded walk, a guard the block does not have: stays safe on any parent table
	function automatic int unsigned root_of(int unsigned c, int unsigned n);
		int unsigned hops = 0;
		while (c < n && parent[c] != c && hops < n) begin
			c = parent[c];
			hops++;
		end
		return (c < n) ? c : 0;
	endfunction

	function automatic bit group_below(int unsigned x, int unsigned y);
		if (comp_size[x] != comp_size[y]) return comp_size[x] < comp_size[y];
		return comp_min[x] < comp_min[y];
	endfunction

	function automatic void build_forest();
		int unsigned n, i, j, k, r, e, f1, f2;
		logic [ksf_pkg::CITY_W-1:0] ka, kb;
		logic [ksf_pkg::LEN_W-1:0] kl;
		int unsigned laid [NCITY];
		n = live_cities();
		k = 0;
		// drop edges that reach past the city range
		for (i = 0; i < edge_cnt; i++)
			if (st_b[i] < n) begin
				st_a[k] = st_a[i];
				st_b[k] = st_b[i];
				st_len[k] = st_len[i];
				k++;
			end
		edge_cnt = k;
		// insertion sort on (length, first city, second city)
		for (i = 1; i < edge_cnt; i++) begin
			ka = st_a[i];
			kb = st_b[i];
			kl = st_len[i];
			j = i;
			while (j > 0 && (kl < st_len[j-1] || (kl == st_len[j-1] &&
					(ka < st_a[j-1] || (ka == st_a[j-1] && kb < st_b[j-1]))))) begin
				st_a[j] = st_a[j-1];
				st_b[j] = st_b[j-1];
				st_len[j] = st_len[j-1];
				j--;
			end
			st_a[j] = ka;
			st_b[j] = kb;
			st_len[j] = kl;
		end
		for (i = 0; i < NCITY; i++) begin
			parent[i] = i;
			comp_size[i] = 0;
			comp_min[i] = i;
		end
		kept_cnt = 0;
		for (i = 0; i < edge_cnt; i++) begin
			f1 = root_of(st_a[i], n);
			f2 = root_of(st_b[i], n);
			if (f1 != f2 && kept_cnt < NCITY) begin
				parent[f2] = f1;
				kept[kept_cnt++] = i;
			end
		end
		for (i = 0; i < n; i++) begin
			r = root_of(i, n);
			if (comp_size[r] == 0) comp_min[r] = i;
			comp_size[r]++;
		end
		// groups: biggest first, then higher smallest member
		grp_cnt = 0;
		for (i = 0; i < n; i++) begin
			if (comp_size[i] == 0) continue;
			j = grp_cnt++;
			while (j > 0 && group_below(grp_order[j-1], i)) begin
				grp_order[j] = grp_order[j-1];
				j--;
			end
			grp_order[j] = i;
		end
		// lay out kept edges group by group, newest first
		k = 0;
		forest_len = 0;
		for (i = 0; i < grp_cnt; i++) begin
			r = grp_order[i];
			forest_len += (comp_size[r] > 1) ? comp_size[r] - 1 : 1;
			for (j = kept_cnt; j > 0; j--) begin
				e = kept[j-1];
				if (root_of(st_a[e], n) == r && k < NCITY) laid[k++] = e;
			end
		end
		for (i = 0; i < k; i++) kept[i] = laid[i];
		kept_cnt = k;
		showing = 1'b1;
		cur_grp = 0;
		cur_pos = 0;
		cur_in_grp = 0;
	endfunction

	// one accepted item; returns 1 with the result when a fetch
	function automatic bit forest_step(input ksf_pkg::ksf_in_t it,
			output ksf_pkg::ksf_res_t res);
		int unsigned r, need, e;
		bit last;
		res = '0;
		if (it.cmd == ksf_pkg::CMD_LOAD) begin
			if (showing) begin
				showing = 1'b0;
				edge_cnt = 0;
				grp_cnt = 0;
			end
			if (edge_cnt < NEDGE) begin
				st_a[edge_cnt] = (it.city_a < it.city_b) ? it.city_a : it.city_b;
				st_b[edge_cnt] = (it.city_a < it.city_b) ? it.city_b : it.city_a;
				st_len[edge_cnt] = it.edge_length;
				edge_cnt++;
			end
			if (it.last_edge) build_forest();
			return 1'b0;
		end
		if (!showing || cur_grp >= grp_cnt) return 1'b1;
		r = grp_order[cur_grp];
		need = comp_size[r] ? comp_size[r] - 1 : 0;
		last = (cur_grp + 1 == grp_cnt);
		res.valid_res = 1'b1;
		if (need == 0 || cur_pos >= kept_cnt) begin
			res.empty_group = 1'b1;
			res.end_of_group = 1'b1;
			res.end_of_forest = last;
			cur_grp++;
			cur_in_grp = 0;
		end else begin
			e = kept[cur_pos];
			res.city_a = st_a[e];
			res.city_b = st_b[e];
			res.length = st_len[e];
			cur_pos++;
			cur_in_grp++;
			if (cur_in_grp >= need) begin
				res.end_of_group = 1'b1;
				res.end_of_forest = last;
				cur_grp++;
				cur_in_grp = 0;
			end
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of items with random gaps between them
	// ------------------------------------------------------------------
	int unsigned burst_left;

	// on return we sit at the falling edge after acceptance, valid still up
	task automatic send_item(input ksf_pkg::ksf_in_t it, input bit plain_idle);
		ksf_pkg::ksf_res_t res;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			// a few long bursts give stretches with no sender idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		cmd <= it.cmd;
		city_a <= it.city_a;
		city_b <= it.city_b;
		edge_length <= it.edge_length;
		last_edge <= it.last_edge;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (forest_step(it, res))
			pending_forest_items.push_back(plain_idle ? ksf_pkg::ksf_res_t'('0) : res);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// sender pauses until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_forest_items.size() != 0);
		@(negedge clk);
	endtask

	task automatic set_cities(input int unsigned v);
		drain();
		// a set that ends in loads yields nothing to wait on: let the
		// forest build finish first
		do @(posedge clk); while (!in_ready);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[ksf_pkg::CC_W-1:0];
		cities_cfg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic ksf_pkg::ksf_in_t load_of(int unsigned a, int unsigned b,
			int unsigned len, bit fin);
		ksf_pkg::ksf_in_t it;
		it.cmd = ksf_pkg::CMD_LOAD;
		it.city_a = a[ksf_pkg::CITY_W-1:0];
		it.city_b = b[ksf_pkg::CITY_W-1:0];
		it.edge_length = len[ksf_pkg::LEN_W-1:0];
		it.last_edge = fin;
		return it;
	endfunction

	// fetch with junk in the unused fields
	function automatic ksf_pkg::ksf_in_t fetch_of();
		ksf_pkg::ksf_in_t it;
		it = ksf_pkg::ksf_in_t'({$urandom, $urandom});
		it.cmd = ksf_pkg::CMD_FETCH;
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Receiver: own stall pattern plus a long hold-off on request
	// ------------------------------------------------------------------
	bit hold_req;
	int unsigned hold_left;
	int unsigned stall_mode, mode_left;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 80);
			end
			mode_left--;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			err_cnt++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		ksf_pkg::ksf_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_forest_items.size() == 0) begin
				err_cnt++;
				$display("%0t: result with none expected, got valid_res %0d a %0d b %0d",
					$time, valid_res, out_city_a, out_city_b);
			end else begin
				want = pending_forest_items.pop_front();
				check_field("valid_res", want.valid_res, valid_res);
				check_field("out_city_a", want.city_a, out_city_a);
				check_field("out_city_b", want.city_b, out_city_b);
				check_field("out_length", want.length, out_length);
				check_field("empty_group", want.empty_group, empty_group);
				check_field("end_of_group", want.end_of_group, end_of_group);
				check_field("end_of_forest", want.end_of_forest, end_of_forest);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still due", $time,
				pending_forest_items.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Random edge set: loads with noise, then fetches (sometimes cut short)
	// ------------------------------------------------------------------
	task automatic random_set(input int unsigned n_edges, input bit with_hold);
		int unsigned n, i, a, b, len, pick, fetches;
		n = live_cities();
		for (i = 0; i < n_edges; i++) begin
			pick = $urandom_range(0, 19);
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, n - 1);
			if (pick < 2) begin
				a = $urandom_range(0, 255);
				b = $urandom_range(0, 255);
			end else if (pick == 2) begin
				b = a;
			end
			case ($urandom_range(0, 3))
				0: len = $urandom_range(0, 7);    // many ties
				1: len = $urandom_range(0, 1) ? 16'hFFFF : 0;
				default: len = $urandom & 16'hFFFF;
			endcase
			// fetch while loading gives an idle item; before the first load it reads the old forest
			if ($urandom_range(0, 19) == 0) send_item(fetch_of(), 1'b0);
			send_item(load_of(a, b, len, i == n_edges - 1), 1'b0);
		end
		fetches = forest_len + $urandom_range(0, 2);
		// broken sequence: the next set abandons this forest part way
		if ($urandom_range(0, 7) == 0) fetches = $urandom_range(0, forest_len);
		// enough fetches to fill the output register and the core behind it
		if (with_hold && fetches < 3) fetches = 3;
		if (with_hold) hold_req = 1'b1;
		for (i = 0; i < fetches; i++) send_item(fetch_of(), 1'b0);
		sets_run++;
	endtask

	typedef struct {
		ksf_pkg::ksf_in_t item;
		bit plain_idle;  // answer typed in: idle item, all fields zero
	} dir_row_t;

	dir_row_t dir_rows [$];

	task automatic add_row(input ksf_pkg::ksf_in_t it, input bit plain_idle);
		dir_row_t row;
		row.item = it;
		row.plain_idle = plain_idle;
		dir_rows.push_back(row);
	endtask

	initial begin
		int unsigned i, n_edges, cc_pick, base_items;
		ksf_pkg::ksf_in_t f;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = ksf_pkg::CMD_LOAD;
		city_a = '0;
		city_b = '0;
		edge_length = '0;
		last_edge = 1'b0;
		out_ready = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		mode_left = 0;
		stall_mode = 0;
		err_cnt = 0;
		items_sent = 0;
		results_seen = 0;
		sets_run = 0;
		cycles = 0;
		burst_left = 0;
		cities_cfg = ksf_pkg::CC_RESET;
		edge_cnt = 0;
		kept_cnt = 0;
		grp_cnt = 0;
		showing = 1'b0;
		forest_len = 0;
		for (i = 0; i < NCITY; i++) begin
			parent[i] = i;
			comp_size[i] = 0;
			comp_min[i] = i;
		end

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// right after reset, under the reset city count: nothing to fetch
		f = fetch_of();
		f.last_edge = 1'b1;
		send_item(f, 1'b1);

		// directed set on six cities
		set_cities(6);
		add_row(fetch_of(), 1'b1);                     // still loading
		add_row(load_of(5, 0, 16'hFFFF, 0), 1'b0);     // reversed endpoints
		add_row(load_of(4, 4, 7, 0), 1'b0);            // self-loop
		add_row(load_of(0, 5, 0, 0), 1'b0);            // parallel, lighter
		add_row(load_of(9, 2, 3, 0), 1'b0);            // out of range
		add_row(load_of(255, 255, 16'hFFFF, 0), 1'b0); // out of range, all ones
		add_row(load_of(2, 3, 0, 1), 1'b0);            // tie on length, ends set
		for (i = 0; i < 4; i++) add_row(fetch_of(), 1'b0);
		add_row(load_of(1, 0, 1, 0), 1'b0);            // abandons the forest
		add_row(fetch_of(), 1'b1);
		add_row(load_of(170, 85, 16'hAAAA, 0), 1'b0);  // dropped at build
		add_row(load_of(0, 1, 16'h5555, 1), 1'b0);
		for (i = 0; i < 6; i++) add_row(fetch_of(), 1'b0);
		add_row(fetch_of(), 1'b1);                     // past the end
		add_row(fetch_of(), 1'b1);
		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].plain_idle);

		// city count of zero acts as one city
		set_cities(0);
		send_item(load_of(0, 0, 3, 0), 1'b0);
		send_item(load_of(0, 1, 4, 1), 1'b0);
		send_item(fetch_of(), 1'b0);
		send_item(fetch_of(), 1'b0);

		// full edge store: ascending lengths keep the sort cheap; the
		// overflow loads are dropped but the final flag still counts;
		// only the head of the forest is read back
		set_cities(511);
		for (i = 0; i < NEDGE + 6; i++)
			send_item(load_of(i & 1, (i & 1) ^ 1, i, i == NEDGE + 5), 1'b0);
		drain();
		for (i = 0; i < FULL_FETCHES; i++) send_item(fetch_of(), 1'b0);

		// random sets over a spread of city counts
		base_items = items_sent;
		while (items_sent - base_items < RANDOM_ITEMS) begin
			if (sets_run % 3 == 0) begin
				cc_pick = $urandom_range(0, 9);
				if (sets_run == 6) set_cities(256);
				else if (sets_run == 15) set_cities(300);
				else if (cc_pick == 0) set_cities($urandom_range(0, 1));
				else if (cc_pick == 1) set_cities(255);
				else set_cities($urandom_range(2, 20));
			end
			n_edges = (live_cities() > 32) ? $urandom_range(10, 40)
				: ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
			random_set(n_edges, sets_run == 1);
			if ($urandom_range(0, 9) == 0) drain();
		end

		drain();
		repeat (50) @(negedge clk);
		if (pending_forest_items.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d results never arrived", $time, pending_forest_items.size());
		end
		$display("Ran %0d items over %0d random edge sets plus directed and full-store sets",
			items_sent, sets_run);
		$display("Checked %0d results, %0d mismatches", results_seen, err_cnt);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* kruskal_spanning_forest.f */
hdl/ksf_pkg.sv
hdl/ksf_ram.sv
hdl/ksf_cmp.sv
hdl/ksf_core.sv
hdl/kruskal_spanning_forest.sv
bench/kruskal_spanning_forest_tb.sv
